### hw/rtl/lzeul_pkg.sv
// ----------------------------------------------------------------------------
// lzeul_pkg: shared types and constants of the lorenz euler step block
// control word layout, op codes, register indexes and fixed-point helpers
// ----------------------------------------------------------------------------
package lzeul_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int COORD_W       = 32;
	localparam int DT_W          = 16;
	localparam int OPND_W        = COORD_W + 1;
	localparam int PROD_W        = 2 * OPND_W;

	// register file
	localparam int REG_IDX_W = 3;
	localparam logic [REG_IDX_W-1:0] REG_START_X   = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_START_Y   = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_START_Z   = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_SIGMA     = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_RHO       = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_BETA      = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_TIME_STEP = 3'd6;

	// reset values, integer part before scaling
	localparam int START_INT = 45;
	localparam int SIGMA_INT = 10;
	localparam int RHO_INT   = 28;
	localparam int BETA_NUM  = 16;
	localparam int BETA_DEN  = 6;
	localparam logic [DT_W-1:0] DT_RESET = 16'd655;

	// microprogram
	localparam int STEP_W    = 4;
	localparam int NUM_STEPS = 10;

	typedef enum logic [1:0] {
		MA_DT,
		MA_DTS,
		MA_X,
		MA_BETA
	} mul_a_t;

	typedef enum logic [3:0] {
		MB_SIGMA,
		MB_Y_MINUS_X,
		MB_RHO_MINUS_Z,
		MB_Y,
		MB_Z,
		MB_IY_LO,
		MB_IY_HI,
		MB_IZ_LO,
		MB_IZ_HI
	} mul_b_t;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_LOAD,
		OP_DTS,
		OP_IZ0,
		OP_IZ1,
		OP_IY,
		OP_LO_Y,
		OP_HI_Y,
		OP_LO_Z,
		OP_HI_Z,
		OP_FIN
	} op_t;

	typedef enum logic [1:0] {
		SEQ_NEXT,
		SEQ_WAIT_ITEM,
		SEQ_JUMP_ROOM,
		SEQ_JUMP
	} seq_t;

	typedef struct packed {
		mul_a_t            a;
		mul_b_t            b;
		op_t               op;
		seq_t              seq;
		logic [STEP_W-1:0] target;
	} ucode_t;

	typedef struct packed {
		ucode_t word;
		logic   go;
	} ctrl_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] start_x;
		logic signed [COORD_W-1:0] start_y;
		logic signed [COORD_W-1:0] start_z;
		logic signed [COORD_W-1:0] sigma;
		logic signed [COORD_W-1:0] rho;
		logic signed [COORD_W-1:0] beta;
		logic        [DT_W-1:0]    time_step;
	} cfg_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_y;
		logic signed [COORD_W-1:0] point_z;
		logic                      saturated;
	} result_t;

	// integer value scaled to fixed point with f fraction bits
	function automatic logic signed [COORD_W-1:0] to_fixed(input int v, input int f);
		return COORD_W'(longint'(v) <<< f);
	endfunction

endpackage

### hw/rtl/lzeul_sequencer.sv
// ----------------------------------------------------------------------------
// lzeul_sequencer: microcode step counter and control store
// steps through the euler program, waits for an item and for output room
// ----------------------------------------------------------------------------
module lzeul_sequencer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	input  logic              room,
	output logic              item_ready,
	output lzeul_pkg::ctrl_t  ctrl
);
	import lzeul_pkg::*;

	logic [STEP_W-1:0] step_q;
	ucode_t            word;
	logic              go;

	// one control word per step; each product lands in the product register
	// and is consumed by the op of the next word
	function automatic ucode_t rom(input logic [STEP_W-1:0] s);
		ucode_t w;
		w = '{MA_DT, MB_SIGMA, OP_NOP, SEQ_JUMP, '0};
		case (s)
			4'd0: w = '{MA_DT,   MB_SIGMA,       OP_LOAD, SEQ_WAIT_ITEM, '0};
			4'd1: w = '{MA_X,    MB_Y,           OP_DTS,  SEQ_NEXT,      '0};
			4'd2: w = '{MA_BETA, MB_Z,           OP_IZ0,  SEQ_NEXT,      '0};
			4'd3: w = '{MA_X,    MB_RHO_MINUS_Z, OP_IZ1,  SEQ_NEXT,      '0};
			4'd4: w = '{MA_DT,   MB_IZ_LO,       OP_IY,   SEQ_NEXT,      '0};
			4'd5: w = '{MA_DT,   MB_IZ_HI,       OP_LO_Z, SEQ_NEXT,      '0};
			4'd6: w = '{MA_DT,   MB_IY_LO,       OP_HI_Z, SEQ_NEXT,      '0};
			4'd7: w = '{MA_DT,   MB_IY_HI,       OP_LO_Y, SEQ_NEXT,      '0};
			4'd8: w = '{MA_DTS,  MB_Y_MINUS_X,   OP_HI_Y, SEQ_NEXT,      '0};
			4'd9: w = '{MA_DT,   MB_SIGMA,       OP_FIN,  SEQ_JUMP_ROOM, '0};
			default: ;
		endcase
		return w;
	endfunction

	assign word = rom(step_q);

	always_comb begin
		case (word.seq)
			SEQ_WAIT_ITEM: go = item_valid;
			SEQ_JUMP_ROOM: go = room;
			default:       go = 1'b1;
		endcase
	end

	assign item_ready = (word.seq == SEQ_WAIT_ITEM);
	assign ctrl.word  = word;
	assign ctrl.go    = go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (go) begin
			if (word.seq == SEQ_JUMP_ROOM || word.seq == SEQ_JUMP) begin
				step_q <= word.target;
			end else begin
				step_q <= step_q + 1'b1;
			end
		end
	end

endmodule

### hw/rtl/lzeul_datapath.sv
// ----------------------------------------------------------------------------
// lzeul_datapath: position registers, shared multiplier and accumulators
// executes one control word per enabled cycle
// ----------------------------------------------------------------------------
module lzeul_datapath #(
	parameter int FRAC_BITS = lzeul_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  lzeul_pkg::ctrl_t   ctrl,
	input  lzeul_pkg::cfg_t    cfg,
	input  logic               restart,
	output lzeul_pkg::result_t res
);
	import lzeul_pkg::*;

	localparam int PF    = PROD_W - FRAC_BITS;  // product after the fraction shift
	localparam int IW    = PF + 1;              // iy / iz
	localparam int SW    = IW + 2;              // sums before clamping
	localparam int SUM_W = COORD_W + 2;
	localparam logic signed [COORD_W-1:0] POS_RST = to_fixed(START_INT, FRAC_BITS);

	logic signed [COORD_W-1:0] pos_x_q, pos_y_q, pos_z_q;
	logic signed [COORD_W-1:0] dts_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [IW-1:0]      iy_q, iz_q;
	logic signed [SUM_W-1:0]   sum_q;
	logic signed [COORD_W-1:0] ny_q, nz_q;
	logic                      sat_q;

	logic signed [OPND_W-1:0]  opnd_a, opnd_b;
	logic signed [PF-1:0]      prod_f;
	logic        [COORD_W-1:0] prod_lo;
	logic signed [SW-1:0]      prod_hi;
	logic        [COORD_W:0]   x_next, hi_next;
	logic signed [COORD_W-1:0] lo_coord;

	// clamp to the coordinate range, top bit flags a clip
	function automatic logic [COORD_W:0] clamp_sum(input logic signed [SW-1:0] v);
		logic [SW-COORD_W:0] hi;
		hi = v[SW-1:COORD_W-1];
		if ((&hi) || !(|hi)) begin
			return {1'b0, v[COORD_W-1:0]};
		end else if (v[SW-1]) begin
			return {1'b1, 1'b1, {(COORD_W-1){1'b0}}};
		end else begin
			return {1'b1, 1'b0, {(COORD_W-1){1'b1}}};
		end
	endfunction

	always_comb begin
		case (ctrl.word.a)
			MA_DT:   opnd_a = $signed({{(OPND_W-DT_W){1'b0}}, cfg.time_step});
			MA_DTS:  opnd_a = OPND_W'(dts_q);
			MA_X:    opnd_a = OPND_W'(pos_x_q);
			MA_BETA: opnd_a = OPND_W'(cfg.beta);
			default: opnd_a = '0;
		endcase
	end

	always_comb begin
		case (ctrl.word.b)
			MB_SIGMA:       opnd_b = OPND_W'(cfg.sigma);
			MB_Y_MINUS_X:   opnd_b = OPND_W'(pos_y_q) - OPND_W'(pos_x_q);
			MB_RHO_MINUS_Z: opnd_b = OPND_W'(cfg.rho) - OPND_W'(pos_z_q);
			MB_Y:           opnd_b = OPND_W'(pos_y_q);
			MB_Z:           opnd_b = OPND_W'(pos_z_q);
			MB_IY_LO:       opnd_b = $signed({1'b0, iy_q[COORD_W-1:0]});
			MB_IY_HI:       opnd_b = OPND_W'($signed(iy_q[IW-1:COORD_W]));
			MB_IZ_LO:       opnd_b = $signed({1'b0, iz_q[COORD_W-1:0]});
			MB_IZ_HI:       opnd_b = OPND_W'($signed(iz_q[IW-1:COORD_W]));
			default:        opnd_b = '0;
		endcase
	end

	// floor shifts are plain part-selects of the registered product
	assign prod_f   = $signed(prod_q[PROD_W-1:FRAC_BITS]);
	assign prod_lo  = prod_q[DT_W+COORD_W-1:DT_W];
	assign prod_hi  = $signed({prod_q[SW-DT_W-1:0], {DT_W{1'b0}}});
	assign lo_coord = (ctrl.word.op == OP_LO_Z) ? pos_z_q : pos_y_q;
	assign x_next   = clamp_sum(SW'(pos_x_q) + SW'(prod_f));
	assign hi_next  = clamp_sum(SW'(sum_q) + prod_hi);

	always_ff @(posedge clk) begin
		if (ctrl.go) begin
			prod_q <= opnd_a * opnd_b;
			case (ctrl.word.op)
				OP_LOAD: sat_q <= 1'b0;
				OP_DTS:  dts_q <= $signed(prod_lo);
				OP_IZ0:  iz_q  <= IW'(prod_f);
				OP_IZ1:  iz_q  <= iz_q - IW'(prod_f);
				OP_IY:   iy_q  <= IW'(prod_f) - IW'(pos_y_q);
				OP_LO_Y, OP_LO_Z: begin
					// low partial product is non-negative
					sum_q <= SUM_W'(lo_coord) + $signed({2'b00, prod_lo});
				end
				OP_HI_Y: begin
					ny_q  <= $signed(hi_next[COORD_W-1:0]);
					sat_q <= sat_q | hi_next[COORD_W];
				end
				OP_HI_Z: begin
					nz_q  <= $signed(hi_next[COORD_W-1:0]);
					sat_q <= sat_q | hi_next[COORD_W];
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q <= POS_RST;
			pos_y_q <= POS_RST;
			pos_z_q <= POS_RST;
		end else if (ctrl.go) begin
			if (ctrl.word.op == OP_LOAD && restart) begin
				pos_x_q <= cfg.start_x;
				pos_y_q <= cfg.start_y;
				pos_z_q <= cfg.start_z;
			end else if (ctrl.word.op == OP_FIN) begin
				pos_x_q <= $signed(x_next[COORD_W-1:0]);
				pos_y_q <= ny_q;
				pos_z_q <= nz_q;
			end
		end
	end

	// point before the update, valid during the finishing step
	assign res.point_x   = pos_x_q;
	assign res.point_y   = pos_y_q;
	assign res.point_z   = pos_z_q;
	assign res.saturated = sat_q | x_next[COORD_W];

endmodule

### hw/rtl/lorenz_euler_step_top.sv
// ----------------------------------------------------------------------------
// lorenz_euler_step_top: lorenz attractor trajectory by forward euler steps
// signed fixed point, one point out per tick item, microcoded datapath
// ----------------------------------------------------------------------------
//
//  channel  dir  signals                        content
//  s_axis   in   tvalid tready tdata[7:0]       restart (bit 0)
//  m_axis   out  tvalid tready tdata[95:0] tuser point_x, point_y, point_z; saturated
//  cfg      in   cfg_we cfg_index cfg_data      register write, no read-back
//
//  one item at a time: the accept step and nine program steps run nine products
//  through one shared 33x33 multiplier; the result is registered on the finishing step
//  the next item can be accepted in the cycle after the result is registered
//  reset loads the default coefficients and puts the point at 45.0 each
//  a result not taken holds the sequencer on its final step; nothing is lost
//
module lorenz_euler_step_top #(
	parameter int FRAC_BITS = lzeul_pkg::FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// slave side
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [7:0]                          s_axis_tdata,   // restart
	// master side
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [3*lzeul_pkg::COORD_W-1:0]     m_axis_tdata,   // point_x, point_y, point_z
	output logic                                m_axis_tuser,   // saturated
	// configuration
	input  logic                                cfg_we,
	input  logic [lzeul_pkg::REG_IDX_W-1:0]     cfg_index,
	input  logic [lzeul_pkg::COORD_W-1:0]       cfg_data
);
	import lzeul_pkg::*;

	localparam logic signed [COORD_W-1:0] START_RST = to_fixed(START_INT, FRAC_BITS);
	localparam logic signed [COORD_W-1:0] SIGMA_RST = to_fixed(SIGMA_INT, FRAC_BITS);
	localparam logic signed [COORD_W-1:0] RHO_RST   = to_fixed(RHO_INT, FRAC_BITS);
	// 8/3 rounded to nearest
	localparam logic signed [COORD_W-1:0] BETA_RST  =
		COORD_W'(((longint'(BETA_NUM) <<< FRAC_BITS) + BETA_DEN / 2) / BETA_DEN);

	cfg_t    cfg_q;
	result_t res;
	result_t out_q;
	logic    out_valid_q;
	ctrl_t   ctrl;
	logic    room;
	logic    fin;

	// configuration registers, out-of-range index ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_x   <= START_RST;
			cfg_q.start_y   <= START_RST;
			cfg_q.start_z   <= START_RST;
			cfg_q.sigma     <= SIGMA_RST;
			cfg_q.rho       <= RHO_RST;
			cfg_q.beta      <= BETA_RST;
			cfg_q.time_step <= DT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_START_X:   cfg_q.start_x   <= cfg_data;
				REG_START_Y:   cfg_q.start_y   <= cfg_data;
				REG_START_Z:   cfg_q.start_z   <= cfg_data;
				REG_SIGMA:     cfg_q.sigma     <= cfg_data;
				REG_RHO:       cfg_q.rho       <= cfg_data;
				REG_BETA:      cfg_q.beta      <= cfg_data;
				REG_TIME_STEP: cfg_q.time_step <= cfg_data[DT_W-1:0];
				default: ;
			endcase
		end
	end

	// output slot is free if empty or being drained this cycle
	assign room = !out_valid_q || m_axis_tready;
	assign fin  = ctrl.go && (ctrl.word.op == OP_FIN);

	lzeul_sequencer u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (s_axis_tvalid),
		.room       (room),
		.item_ready (s_axis_tready),
		.ctrl       (ctrl)
	);

	lzeul_datapath #(
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (ctrl),
		.cfg     (cfg_q),
		.restart (s_axis_tdata[0]),
		.res     (res)
	);

	// output register parts the result from the sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_q.point_z, out_q.point_y, out_q.point_x};
	assign m_axis_tuser  = out_q.saturated;

`ifndef NO_ASSERTIONS
	// one item at a time: busy right after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("item accepted while previous item still in work");

	// a finished item never overwrites a pending result
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		fin |-> (!m_axis_tvalid || m_axis_tready))
		else $error("result register overwritten before it was taken");

	// a result appears only after the finishing step
	a_valid_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(fin))
		else $error("output valid without a finished item");
`endif

endmodule

### tb/lorenz_euler_step_top_tb.sv
// ----------------------------------------------------------------------------
// lorenz_euler_step_top_tb: self-checking bench for the lorenz euler stepper
// a queue-fed driver sends tick items with random gaps, a monitor predicts
// each point in wide signed arithmetic and compares every field of every
// result; the receiver stalls at random and once for a long stretch
// ----------------------------------------------------------------------------
module lorenz_euler_step_top_tb;

	import lzeul_pkg::*;

	localparam int FRAC            = FRAC_BITS_DEF;
	localparam int ONE             = 1 <<< FRAC;
	localparam int MAX_GAP         = 15;
	localparam int LONG_HOLD       = 400;
	localparam int RAND_PHASES     = 10;
	localparam int ITEMS_PER_PHASE = 195;
	localparam int PRESSURE_PHASE  = 2;
	localparam int END_SETTLE      = 24;
	localparam int LIMIT_CYCLES    = 800000;

	// wide enough that no product or shift of the datapath can overflow
	typedef logic signed [127:0] wide_t;
	localparam wide_t COORD_MAX = (wide_t'(1) <<< (COORD_W - 1)) - wide_t'(1);
	localparam wide_t COORD_MIN = -COORD_MAX - wide_t'(1);

	// how a random phase picks its coefficients
	typedef enum logic [1:0] {
		CFG_FLOW,     // near the classic attractor, long bounded trajectories
		CFG_NOISE,    // any 32-bit pattern, mostly clipping
		CFG_EXTREME   // corners of each register range, zero, minus one and one
	} cfg_mode_t;

	// clock and reset
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// block ports, all known from time zero
	logic                   s_tvalid  = 1'b0;
	wire                    s_axis_tready;
	logic [7:0]             s_tdata   = '0;     // restart
	wire                    m_axis_tvalid;
	logic                   m_tready  = 1'b0;
	wire  [3*COORD_W-1:0]   m_axis_tdata;       // point_x, point_y, point_z
	wire                    m_axis_tuser;       // saturated
	logic                   cfg_we    = 1'b0;
	logic [REG_IDX_W-1:0]   cfg_index = '0;
	logic [COORD_W-1:0]     cfg_data  = '0;

	lorenz_euler_step_top #(
		.FRAC_BITS(FRAC)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// predictor copy of the registers and of the current point
	cfg_t                       model_cfg;
	logic signed [COORD_W-1:0]  cur_x, cur_y, cur_z;

	// restart bits waiting to go out, points the block still owes
	logic       ticks_to_send[$];
	result_t    points_due[$];
	result_t    want, got;

	// handshake bookkeeping
	logic       in_accepted  = 1'b0;
	logic       out_accepted = 1'b0;
	int         src_gap_max  = MAX_GAP;
	int         sink_gap_max = MAX_GAP;
	int         src_wait     = 0;
	int         sink_wait    = 0;
	int         sink_draw;
	int         hold_asked   = 0;
	int         hold_served  = 0;
	int         hold_left    = 0;
	int         error_count  = 0;
	int         cycle_count;

	// clip a wide sum to 32 bits, top bit says it was clipped
	function automatic logic [COORD_W:0] clip_coord(input wide_t v);
		if (v > COORD_MAX)
			return {1'b1, COORD_W'(COORD_MAX)};
		if (v < COORD_MIN)
			return {1'b1, COORD_W'(COORD_MIN)};
		return {1'b0, COORD_W'(v)};
	endfunction

	// one euler step: returns the point before the update, moves the point
	function automatic result_t lorenz_advance(input logic restart);
		wide_t x, y, z, dt, sig, rh, bt, dts, dx, iy, dy, iz, dz;
		logic signed [COORD_W-1:0] nx, ny, nz;
		logic sat_x, sat_y, sat_z;
		result_t r;
		// restart picks up the start registers as they are right now
		if (restart) begin
			cur_x = model_cfg.start_x;
			cur_y = model_cfg.start_y;
			cur_z = model_cfg.start_z;
		end
		x   = wide_t'(cur_x);
		y   = wide_t'(cur_y);
		z   = wide_t'(cur_z);
		dt  = wide_t'(model_cfg.time_step);
		sig = wide_t'(model_cfg.sigma);
		rh  = wide_t'(model_cfg.rho);
		bt  = wide_t'(model_cfg.beta);
		// arithmetic shifts on signed operands floor toward minus infinity
		dts = (dt * sig) >>> DT_W;
		dx  = (dts * (y - x)) >>> FRAC;
		iy  = ((x * (rh - z)) >>> FRAC) - y;
		dy  = (dt * iy) >>> DT_W;
		iz  = ((x * y) >>> FRAC) - ((bt * z) >>> FRAC);
		dz  = (dt * iz) >>> DT_W;
		{sat_x, nx} = clip_coord(x + dx);
		{sat_y, ny} = clip_coord(y + dy);
		{sat_z, nz} = clip_coord(z + dz);
		r.point_x   = cur_x;
		r.point_y   = cur_y;
		r.point_z   = cur_z;
		r.saturated = sat_x | sat_y | sat_z;
		cur_x = nx;
		cur_y = ny;
		cur_z = nz;
		return r;
	endfunction

	// one register write on the falling edge, mirrored into the predictor
	task automatic set_register(input logic [REG_IDX_W-1:0] idx, input logic [COORD_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			REG_START_X:   model_cfg.start_x   = val;
			REG_START_Y:   model_cfg.start_y   = val;
			REG_START_Z:   model_cfg.start_z   = val;
			REG_SIGMA:     model_cfg.sigma     = val;
			REG_RHO:       model_cfg.rho       = val;
			REG_BETA:      model_cfg.beta      = val;
			REG_TIME_STEP: model_cfg.time_step = val[DT_W-1:0];   // upper bits dropped
			default: ;                                            // off the list, ignored
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// sender pauses here until every owed point has come back
	task automatic wait_all_points();
		while (ticks_to_send.size() != 0 || s_tvalid || points_due.size() != 0)
			@(posedge clk);
	endtask

	// driver: next tick item on the falling edge once the last one was taken and its gap has run out
	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			src_wait <= 0;
		end else if (!s_tvalid || in_accepted) begin
			if (src_wait != 0) begin
				s_tvalid <= 1'b0;
				src_wait <= src_wait - 1;
			end else if (ticks_to_send.size() != 0) begin
				s_tvalid <= 1'b1;
				s_tdata  <= {7'b0, ticks_to_send.pop_front()};
				// gap that follows this item once it is accepted
				src_wait <= $urandom_range(0, src_gap_max);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver: random wait after each result, plus a long hold on request
	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready  <= 1'b0;
			sink_wait <= 0;
			hold_left <= 0;
		end else if (hold_served != hold_asked) begin
			hold_served <= hold_asked;
			hold_left   <= LONG_HOLD;
			m_tready    <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (m_tready) begin
			if (out_accepted) begin
				sink_draw = $urandom_range(0, sink_gap_max);
				if (sink_draw != 0) begin
					m_tready  <= 1'b0;
					sink_wait <= sink_draw - 1;
				end
			end
		end else if (sink_wait != 0) begin
			sink_wait <= sink_wait - 1;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// monitor: predict on input acceptance, check on output acceptance
	always @(posedge clk) begin
		if (!arst_n) begin
			in_accepted  <= 1'b0;
			out_accepted <= 1'b0;
		end else begin
			in_accepted  <= s_tvalid && s_axis_tready;
			out_accepted <= m_axis_tvalid && m_tready;
			if (s_tvalid && s_axis_tready)
				points_due.push_back(lorenz_advance(s_tdata[0]));
			if (m_axis_tvalid && m_tready) begin
				got.point_x   = m_axis_tdata[COORD_W-1:0];
				got.point_y   = m_axis_tdata[2*COORD_W-1:COORD_W];
				got.point_z   = m_axis_tdata[3*COORD_W-1:2*COORD_W];
				got.saturated = m_axis_tuser;
				if (points_due.size() == 0) begin
					$error("point with nothing owed: x %0d y %0d z %0d",
						got.point_x, got.point_y, got.point_z);
					error_count++;
				end else begin
					want = points_due.pop_front();
					if (got.point_x !== want.point_x) begin
						$error("point_x: expected %0d, got %0d", want.point_x, got.point_x);
						error_count++;
					end
					if (got.point_y !== want.point_y) begin
						$error("point_y: expected %0d, got %0d", want.point_y, got.point_y);
						error_count++;
					end
					if (got.point_z !== want.point_z) begin
						$error("point_z: expected %0d, got %0d", want.point_z, got.point_z);
						error_count++;
					end
					if (got.saturated !== want.saturated) begin
						$error("saturated: expected %0b, got %0b",
							want.saturated, got.saturated);
						error_count++;
					end
				end
			end
		end
	end

	// watchdog on total run length
	initial begin
		cycle_count = 0;
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("lorenz_euler_step_top_tb: done, errors");
		$finish;
	end

	// stimulus sequence
	initial begin
		int                     phase, n, r;
		int                     restart_pct;
		cfg_mode_t              mode;
		logic [REG_IDX_W-1:0]   idx;
		logic [COORD_W-1:0]     val;

		// predictor starts from the reset values of the block
		model_cfg.start_x   = START_INT * ONE;
		model_cfg.start_y   = START_INT * ONE;
		model_cfg.start_z   = START_INT * ONE;
		model_cfg.sigma     = SIGMA_INT * ONE;
		model_cfg.rho       = RHO_INT * ONE;
		model_cfg.beta      = (BETA_NUM * ONE + BETA_DEN / 2) / BETA_DEN;
		model_cfg.time_step = DT_RESET;
		cur_x = model_cfg.start_x;
		cur_y = model_cfg.start_y;
		cur_z = model_cfg.start_z;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset state and reset coefficients, restart in the middle
		ticks_to_send = {ticks_to_send, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0};
		wait_all_points();

		// everything at its top or bottom, dt at full scale via junk upper bits
		set_register(REG_START_X, 32'h7fff_ffff);
		set_register(REG_START_Y, 32'h8000_0000);
		set_register(REG_START_Z, 32'h7fff_ffff);
		set_register(REG_SIGMA, 32'h7fff_ffff);
		set_register(REG_RHO, 32'h8000_0000);
		set_register(REG_BETA, 32'h7fff_ffff);
		set_register(REG_TIME_STEP, 32'hffff_ffff);
		ticks_to_send = {ticks_to_send, 1'b1, 1'b0, 1'b0, 1'b0};
		wait_all_points();

		// opposite corners with dt zero, point must stand still
		set_register(REG_START_X, 32'h8000_0000);
		set_register(REG_START_Y, 32'h8000_0000);
		set_register(REG_START_Z, 32'h8000_0000);
		set_register(REG_SIGMA, 32'h8000_0000);
		set_register(REG_RHO, 32'h7fff_ffff);
		set_register(REG_BETA, 32'h8000_0000);
		set_register(REG_TIME_STEP, 32'hffff_0000);
		ticks_to_send = {ticks_to_send, 1'b1, 1'b0};
		wait_all_points();

		// tiny values, smallest dt, and a write to an index off the list
		set_register(REG_START_X, 32'd1);
		set_register(REG_START_Y, 32'hffff_ffff);
		set_register(REG_START_Z, 32'd0);
		set_register(REG_SIGMA, ONE);
		set_register(REG_RHO, 32'hffff_ffff);
		set_register(REG_BETA, 32'd0);
		set_register(REG_TIME_STEP, 32'd1);
		set_register(REG_IDX_W'(int'(REG_TIME_STEP) + 1), $urandom);
		ticks_to_send = {ticks_to_send, 1'b1, 1'b0, 1'b1};
		wait_all_points();

		// back to the classic attractor
		set_register(REG_START_X, START_INT * ONE);
		set_register(REG_START_Y, START_INT * ONE);
		set_register(REG_START_Z, START_INT * ONE);
		set_register(REG_SIGMA, SIGMA_INT * ONE);
		set_register(REG_RHO, RHO_INT * ONE);
		set_register(REG_BETA, (BETA_NUM * ONE + BETA_DEN / 2) / BETA_DEN);
		set_register(REG_TIME_STEP, DT_RESET);
		ticks_to_send = {ticks_to_send, 1'b1, 1'b0, 1'b0, 1'b0};
		wait_all_points();

		// new start x takes effect only on the next restart
		set_register(REG_START_X, -(3 * ONE));
		ticks_to_send = {ticks_to_send, 1'b0, 1'b0, 1'b1, 1'b0};
		wait_all_points();

		// random phases, each with its own coefficient set and pacing
		for (phase = 0; phase < RAND_PHASES; phase++) begin
			if (phase % 2 == 0)
				mode = CFG_FLOW;
			else if (phase % 4 == 1)
				mode = CFG_NOISE;
			else
				mode = CFG_EXTREME;
			src_gap_max  = (phase % 5 == 2) ? 0 : MAX_GAP;
			sink_gap_max = (phase % 5 == 4 || phase == 7) ? 0 : MAX_GAP;
			restart_pct  = (mode == CFG_FLOW) ? 2 : 10;

			for (r = 0; r <= int'(REG_TIME_STEP); r++) begin
				idx = REG_IDX_W'(r);
				case (mode)
					CFG_NOISE: begin
						val = $urandom;
					end
					CFG_EXTREME: begin
						case ($urandom_range(0, 4))
							0: val = 32'h7fff_ffff;
							1: val = 32'h8000_0000;
							2: val = 32'h0000_0000;
							3: val = 32'hffff_ffff;
							default: val = ONE;
						endcase
					end
					default: begin
						// small perturbations around sigma 10, rho 28, beta 8/3
						case (idx)
							REG_SIGMA: val = SIGMA_INT * ONE - ONE
								+ int'($urandom_range(0, 2 * ONE));
							REG_RHO: val = RHO_INT * ONE - 4 * ONE
								+ int'($urandom_range(0, 8 * ONE));
							REG_BETA: val = (BETA_NUM * ONE) / BETA_DEN - ONE / 2
								+ int'($urandom_range(0, ONE));
							REG_TIME_STEP: val = $urandom_range(50, 1500);
							default: val = int'($urandom_range(0, 80 * ONE)) - 40 * ONE;
						endcase
					end
				endcase
				set_register(idx, val);
			end

			for (n = 0; n < ITEMS_PER_PHASE; n++)
				ticks_to_send.push_back((n == 0) || ($urandom_range(0, 99) < restart_pct));
			// receiver stalls long while the sender keeps offering
			if (phase == PRESSURE_PHASE)
				hold_asked++;
			wait_all_points();
		end

		repeat (END_SETTLE) @(posedge clk);
		if (error_count == 0)
			$display("lorenz_euler_step_top_tb: done, clean");
		else
			$display("lorenz_euler_step_top_tb: done, errors");
		$finish;
	end

endmodule
